[rtl/core/reo_pkg.sv]
// reo_pkg: shared types and constants for the rotary encoder position qualifier
// used by reo_qualifier, reo_out_buffer and rotary_encoder_position_qualifier
`timescale 1ns / 1ps

package reo_pkg;

	localparam int unsigned CFG_WIDTH = 20;
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE         = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROTARY_HOLDOFF = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUTTON_HOLDOFF = 2'd2;

	localparam logic [CFG_WIDTH-1:0] SETTLE_RESET         = 20'd8000;
	localparam logic [CFG_WIDTH-1:0] ROTARY_HOLDOFF_RESET = 20'd15000;
	localparam logic [CFG_WIDTH-1:0] BUTTON_HOLDOFF_RESET = 20'd150000;

	// qualification phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// event source codes
	localparam logic [1:0] SRC_A   = 2'd0;
	localparam logic [1:0] SRC_B   = 2'd1;
	localparam logic [1:0] SRC_BTN = 2'd2;

	typedef struct packed {
		logic pin_a;
		logic pin_b;
		logic pin_button;
	} tick_t;

	typedef struct packed {
		logic [3:0] position_leds;
		logic       idle_led;
		logic [1:0] position;
		logic       enabled;
	} result_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] settle_ticks;
		logic [CFG_WIDTH-1:0] rotary_holdoff_ticks;
		logic [CFG_WIDTH-1:0] button_holdoff_ticks;
	} cfg_t;

endpackage

[rtl/core/reo_qualifier.sv]
// reo_qualifier: edge detection, pin qualification and position/enable state
// depends on reo_pkg
`timescale 1ns / 1ps

module reo_qualifier import reo_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 20
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  tick_t   tick,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	logic                   prev_a_q, prev_b_q, prev_btn_q;
	logic [1:0]             phase_q, src_q;
	logic                   first_q;
	logic [COUNT_WIDTH-1:0] win_q, rot_q, btn_q;
	logic [1:0]             pos_q;
	logic                   en_q;

	logic [1:0]             phase_d, src_d, pos_d;
	logic                   first_d, en_d;
	logic [COUNT_WIDTH-1:0] win_d, rot_d, btn_d;
	logic [COUNT_WIDTH-1:0] win_inc, rot_inc, btn_inc;
	logic                   busy, lvl, settled, rot_ok, btn_ok;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	assign win_inc = sat_inc(win_q);
	assign rot_inc = sat_inc(rot_q);
	assign btn_inc = sat_inc(btn_q);

	assign busy = (phase_q == PH_FIRST || phase_q == PH_SECOND) &&
		(src_q == SRC_A || src_q == SRC_B || src_q == SRC_BTN);

	assign settled = CMP_W'(win_inc) >= CMP_W'(cfg.settle_ticks);
	assign rot_ok  = CMP_W'(rot_inc) > CMP_W'(cfg.rotary_holdoff_ticks);
	assign btn_ok  = CMP_W'(btn_inc) > CMP_W'(cfg.button_holdoff_ticks);

	// pin under test in the current phase
	always_comb begin
		if (src_q == SRC_BTN) begin
			lvl = tick.pin_button;
		end else if (phase_q == PH_FIRST) begin
			lvl = (src_q == SRC_A) ? tick.pin_b : tick.pin_a;
		end else begin
			lvl = (src_q == SRC_A) ? tick.pin_a : tick.pin_b;
		end
	end

	always_comb begin
		phase_d = phase_q;
		src_d   = src_q;
		first_d = first_q;
		win_d   = win_q;
		rot_d   = rot_inc;
		btn_d   = btn_inc;
		pos_d   = pos_q;
		en_d    = en_q;
		if (busy) begin
			win_d = win_inc;
			if (settled) begin
				priority if (lvl != first_q) begin
					first_d = lvl;
					win_d   = '0;
				end else if (src_q == SRC_BTN) begin
					if (lvl) begin
						en_d  = ~en_q;
						btn_d = '0;
					end
					phase_d = PH_IDLE;
				end else if (phase_q == PH_FIRST) begin
					if (lvl) begin
						phase_d = PH_SECOND;
						first_d = (src_q == SRC_A) ? tick.pin_a : tick.pin_b;
						win_d   = '0;
					end else begin
						phase_d = PH_IDLE;
					end
				end else begin
					if (!lvl) begin
						pos_d = (src_q == SRC_A) ? pos_q + 2'd1 : pos_q - 2'd1;
						rot_d = '0;
					end
					phase_d = PH_IDLE;
				end
			end
		end else begin
			phase_d = PH_IDLE;
			priority if (prev_a_q && !tick.pin_a && rot_ok) begin
				phase_d = PH_FIRST;
				src_d   = SRC_A;
				first_d = tick.pin_b;
				win_d   = '0;
			end else if (prev_b_q && !tick.pin_b && rot_ok) begin
				phase_d = PH_FIRST;
				src_d   = SRC_B;
				first_d = tick.pin_a;
				win_d   = '0;
			end else if (!prev_btn_q && tick.pin_button && btn_ok) begin
				phase_d = PH_FIRST;
				src_d   = SRC_BTN;
				first_d = tick.pin_button;
				win_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q   <= 1'b1;
			prev_b_q   <= 1'b1;
			prev_btn_q <= 1'b0;
			phase_q    <= PH_IDLE;
			src_q      <= SRC_A;
			first_q    <= 1'b0;
			win_q      <= '0;
			rot_q      <= '0;
			btn_q      <= '0;
			pos_q      <= 2'd0;
			en_q       <= 1'b0;
		end else if (step) begin
			prev_a_q   <= tick.pin_a;
			prev_b_q   <= tick.pin_b;
			prev_btn_q <= tick.pin_button;
			phase_q    <= phase_d;
			src_q      <= src_d;
			first_q    <= first_d;
			win_q      <= win_d;
			rot_q      <= rot_d;
			btn_q      <= btn_d;
			pos_q      <= pos_d;
			en_q       <= en_d;
		end
	end

	// result reflects the state after this tick
	assign result.position_leds = en_d ? (4'd1 << pos_d) : 4'd0;
	assign result.idle_led      = ~en_d;
	assign result.position      = pos_d;
	assign result.enabled       = en_d;

`ifndef SYNTHESIS
	a_step_clears_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != $past(pos_q)) |-> (rot_q == '0))
		else $error("position moved without restarting rotary holdoff");

	a_toggle_clears_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		(en_q != $past(en_q)) |-> (btn_q == '0))
		else $error("enable toggled without restarting button holdoff");

	a_button_single_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SECOND) |-> (src_q != SRC_BTN))
		else $error("button qualification entered second phase");
`endif

endmodule

[rtl/core/reo_out_buffer.sv]
// reo_out_buffer: two-entry output buffer (output register plus skid entry)
// depends on reo_pkg
`timescale 1ns / 1ps

module reo_out_buffer import reo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    has_room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q, skid_valid_q;
	result_t out_data_q, skid_data_q;
	logic    load_out;

	assign has_room  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	// output register frees up this cycle
	assign load_out  = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");
`endif

endmodule

[rtl/core/rotary_encoder_position_qualifier.sv]
// rotary_encoder_position_qualifier: top level, configuration registers and handshake
// depends on reo_pkg, reo_qualifier, reo_out_buffer
`timescale 1ns / 1ps

// Debounced rotary encoder with push-button enable. Each input transaction is one
// timebase tick carrying the A, B and button levels; each tick yields exactly one
// output transaction with the position LEDs, idle LED, position and enable flag as
// they stand after that tick. A tick can be taken every clock cycle: the whole
// state update is one short combinational pass from the state registers into the
// next state and the result, so throughput is one transaction per cycle while the
// output buffer has room. This two-entry buffer (output register plus skid entry)
// takes one more tick after the consumer stalls; in_ready drops only when both
// entries hold results. The settle window and the two holdoffs are set through the
// write port (index 0 settle, 1 rotary holdoff, 2 button holdoff; other indexes are
// ignored) and should only be changed while idle.
// COUNT_WIDTH sets the width of the saturating tick counters.

module rotary_encoder_position_qualifier import reo_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	// tick input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tick_t                      in_data,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output result_t                    out_data
);

	cfg_t    cfg_q;
	result_t result;
	logic    step;
	logic    has_room;

	// configuration registers, written in place with no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks         <= SETTLE_RESET;
			cfg_q.rotary_holdoff_ticks <= ROTARY_HOLDOFF_RESET;
			cfg_q.button_holdoff_ticks <= BUTTON_HOLDOFF_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SETTLE:         cfg_q.settle_ticks         <= cfg_data;
				REG_ROTARY_HOLDOFF: cfg_q.rotary_holdoff_ticks <= cfg_data;
				REG_BUTTON_HOLDOFF: cfg_q.button_holdoff_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// a tick is a transaction whenever the output buffer has a free entry
	assign in_ready = has_room;
	assign step     = in_valid & has_room;

	// state update for one tick
	reo_qualifier #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_qualifier (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (in_data),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register with skid entry
	reo_out_buffer u_out_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (result),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
